@@ hdl/bpc_pkg.sv @@
package bpc_pkg;

  // Sizing of the count table
  localparam int unsigned MAX_AMOUNT = 1023;
  localparam int unsigned LIMBS      = 20;
  localparam int unsigned DEPTH      = (MAX_AMOUNT + 1) * LIMBS;

  // Field widths
  localparam int unsigned AMT_W  = 10;
  localparam int unsigned LIMB_W = 14;
  localparam int unsigned POS_W  = 5;

  // Derived widths
  localparam int unsigned N_W    = $clog2(MAX_AMOUNT + 1);
  localparam int unsigned CMP_W  = (N_W > AMT_W) ? N_W : AMT_W;
  localparam int unsigned LIDX_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  localparam logic [LIMB_W-1:0] LIMB_BASE = LIMB_W'(10000);

  // Read-modify-write request for one limb of the destination entry
  typedef struct packed {
    logic              valid;
    logic              first;
    logic [ADDR_W-1:0] addr;
  } add_req_t;

  // Table write port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [LIMB_W-1:0] data;
  } mem_wr_t;

endpackage

@@ hdl/bpc_if.sv @@
interface bpc_query_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::AMT_W-1:0]  amount;
  logic [bpc_pkg::AMT_W-1:0]  max_part;

  modport source (output valid, output amount, output max_part, input ready);
  modport sink (input valid, input amount, input max_part, output ready);
endinterface

interface bpc_count_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::LIMB_W-1:0] limb;
  logic [bpc_pkg::POS_W-1:0]  limb_index;
  logic                       last;

  modport source (output valid, output limb, output limb_index, output last, input ready);
  modport sink (input valid, input limb, input limb_index, input last, output ready);
endinterface

@@ hdl/bpc_mem.sv @@
module bpc_mem (
  input  logic                          clk_i,
  input  bpc_pkg::mem_wr_t              wr_i,
  input  logic [bpc_pkg::ADDR_W-1:0]    raddr_a_i,
  input  logic [bpc_pkg::ADDR_W-1:0]    raddr_b_i,
  output logic [bpc_pkg::LIMB_W-1:0]    rdata_a_o,
  output logic [bpc_pkg::LIMB_W-1:0]    rdata_b_o
);

  logic [bpc_pkg::LIMB_W-1:0] mem_q [bpc_pkg::DEPTH];
  logic [bpc_pkg::LIMB_W-1:0] rdata_a_q;
  logic [bpc_pkg::LIMB_W-1:0] rdata_b_q;

  // Write one limb; reads return the word being written to the same address
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_a_q <= (wr_i.we && (wr_i.addr == raddr_a_i)) ? wr_i.data : mem_q[raddr_a_i];
    rdata_b_q <= (wr_i.we && (wr_i.addr == raddr_b_i)) ? wr_i.data : mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hdl/bpc_adder.sv @@
module bpc_adder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpc_pkg::add_req_t             req_i,
  input  logic [bpc_pkg::LIMB_W-1:0]    dst_i,
  input  logic [bpc_pkg::LIMB_W-1:0]    src_i,
  output bpc_pkg::mem_wr_t              wr_o
);

  logic                          valid_q;
  logic                          first_q;
  logic [bpc_pkg::ADDR_W-1:0]    addr_q;
  logic                          carry_q;
  logic                          carry_d;
  logic                          carry_in;
  logic [bpc_pkg::LIMB_W:0]      sum;
  logic [bpc_pkg::LIMB_W:0]      sum_wrap;

  // Hold the request while the table read is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      first_q <= 1'b0;
      carry_q <= 1'b0;
    end else begin
      valid_q <= req_i.valid;
      first_q <= req_i.first;
      if (valid_q) begin
        carry_q <= carry_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= req_i.addr;
  end

  // Add one base-10000 limb with carry; the carry restarts on limb zero
  always_comb begin
    carry_in = first_q ? 1'b0 : carry_q;
    sum      = {1'b0, dst_i} + {1'b0, src_i} + {{bpc_pkg::LIMB_W{1'b0}}, carry_in};
    sum_wrap = sum - {1'b0, bpc_pkg::LIMB_BASE};
    carry_d  = (sum >= {1'b0, bpc_pkg::LIMB_BASE});
    wr_o.we   = valid_q;
    wr_o.addr = addr_q;
    wr_o.data = carry_d ? sum_wrap[bpc_pkg::LIMB_W-1:0] : sum[bpc_pkg::LIMB_W-1:0];
  end

  a_limb_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> (wr_o.data < bpc_pkg::LIMB_BASE))
    else $error("limb written back out of base-10000 range");

endmodule

@@ hdl/bounded_partition_counter.sv @@
// Channel  Dir  Words                           Handshake
// query_i  in   amount, max_part                valid/ready, one word per query
// count_o  out  limb, limb_index, last          valid/ready, one word per limb
//
// One query at a time; query_i.ready is high only while the block is idle.
// Clear writes each limb of rows 0..amount; update does a read-modify-write of each limb
// for every part k=1..max_part and entry n=k..amount, one limb per cycle on the table port.
// Readout reads and checks limbs top first, skips leading zero limbs and sends the rest.
// Reset clears only control state; the table holds no reset value and is rebuilt per query.
// A stalled count_o holds its word and the sequencer waits.
module bounded_partition_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpc_query_if.sink   query_i,
  bpc_count_if.source count_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLEAR    = 3'd1;
  localparam logic [2:0] S_ADD      = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_SEND     = 3'd5;

  localparam logic [bpc_pkg::LIDX_W-1:0] LAST_LIMB = bpc_pkg::LIDX_W'(bpc_pkg::LIMBS - 1);
  localparam logic [bpc_pkg::ADDR_W-1:0] ROW_STEP  = bpc_pkg::ADDR_W'(bpc_pkg::LIMBS);

  logic [2:0]                    state_q, state_d;
  logic [bpc_pkg::N_W-1:0]       amt_q, amt_d;
  logic [bpc_pkg::N_W-1:0]       kmax_q, kmax_d;
  logic [bpc_pkg::N_W-1:0]       k_q, k_d;
  logic [bpc_pkg::N_W-1:0]       n_q, n_d;
  logic [bpc_pkg::LIDX_W-1:0]    i_q, i_d;
  logic [bpc_pkg::ADDR_W-1:0]    dbase_q, dbase_d;
  logic [bpc_pkg::ADDR_W-1:0]    kbase_q, kbase_d;
  logic                          lead_q, lead_d;
  logic [bpc_pkg::LIMB_W-1:0]    limb_q, limb_d;
  logic                          out_valid_q, out_valid_d;

  logic [bpc_pkg::CMP_W-1:0]     amt_ext;
  logic [bpc_pkg::CMP_W-1:0]     mp_ext;
  logic [bpc_pkg::N_W-1:0]       amt_sat;
  logic [bpc_pkg::N_W-1:0]       mp_sat;

  logic [bpc_pkg::ADDR_W-1:0]    raddr_a;
  logic [bpc_pkg::ADDR_W-1:0]    raddr_b;
  logic [bpc_pkg::LIMB_W-1:0]    rdata_a;
  logic [bpc_pkg::LIMB_W-1:0]    rdata_b;
  bpc_pkg::add_req_t             add_req;
  bpc_pkg::mem_wr_t              add_wr;
  bpc_pkg::mem_wr_t              clr_wr;
  bpc_pkg::mem_wr_t              mem_wr;

  // Clamp the query to the table size, and the part limit to the amount
  always_comb begin
    amt_ext = bpc_pkg::CMP_W'(query_i.amount);
    mp_ext  = bpc_pkg::CMP_W'(query_i.max_part);
    amt_sat = (amt_ext > bpc_pkg::CMP_W'(bpc_pkg::MAX_AMOUNT)) ?
              bpc_pkg::N_W'(bpc_pkg::MAX_AMOUNT) : bpc_pkg::N_W'(amt_ext);
    mp_sat  = (mp_ext > bpc_pkg::CMP_W'(amt_sat)) ? amt_sat : bpc_pkg::N_W'(mp_ext);
  end

  // Destination limb n*LIMBS+i and source limb (n-k)*LIMBS+i
  assign raddr_a = dbase_q + bpc_pkg::ADDR_W'(i_q);
  assign raddr_b = dbase_q - kbase_q + bpc_pkg::ADDR_W'(i_q);

  // Sequencer: clear rows, sweep part sizes, then read out the count
  always_comb begin
    state_d     = state_q;
    amt_d       = amt_q;
    kmax_d      = kmax_q;
    k_d         = k_q;
    n_d         = n_q;
    i_d         = i_q;
    dbase_d     = dbase_q;
    kbase_d     = kbase_q;
    lead_d      = lead_q;
    limb_d      = limb_q;
    out_valid_d = out_valid_q;
    clr_wr      = '0;
    add_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (query_i.valid) begin
          amt_d   = amt_sat;
          kmax_d  = mp_sat;
          n_d     = '0;
          i_d     = '0;
          dbase_d = '0;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        clr_wr.we   = 1'b1;
        clr_wr.addr = raddr_a;
        clr_wr.data = ((n_q == '0) && (i_q == '0)) ? bpc_pkg::LIMB_W'(1) : '0;
        if (i_q == LAST_LIMB) begin
          i_d = '0;
          if (n_q == amt_q) begin
            if (kmax_q == '0) begin
              i_d     = LAST_LIMB;
              lead_d  = 1'b1;
              state_d = S_SCAN_RD;
            end else begin
              k_d     = bpc_pkg::N_W'(1);
              n_d     = bpc_pkg::N_W'(1);
              kbase_d = ROW_STEP;
              dbase_d = ROW_STEP;
              state_d = S_ADD;
            end
          end else begin
            n_d     = n_q + bpc_pkg::N_W'(1);
            dbase_d = dbase_q + ROW_STEP;
          end
        end else begin
          i_d = i_q + bpc_pkg::LIDX_W'(1);
        end
      end
      S_ADD: begin
        add_req.valid = 1'b1;
        add_req.first = (i_q == '0);
        add_req.addr  = raddr_a;
        if (i_q == LAST_LIMB) begin
          i_d = '0;
          if (n_q == amt_q) begin
            if (k_q == kmax_q) begin
              i_d     = LAST_LIMB;
              lead_d  = 1'b1;
              state_d = S_SCAN_RD;
            end else begin
              k_d     = k_q + bpc_pkg::N_W'(1);
              n_d     = k_q + bpc_pkg::N_W'(1);
              kbase_d = kbase_q + ROW_STEP;
              dbase_d = kbase_q + ROW_STEP;
            end
          end else begin
            n_d     = n_q + bpc_pkg::N_W'(1);
            dbase_d = dbase_q + ROW_STEP;
          end
        end else begin
          i_d = i_q + bpc_pkg::LIDX_W'(1);
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        // Drop leading zero limbs, but always send limb zero
        if (lead_q && (rdata_a == '0) && (i_q != '0)) begin
          i_d     = i_q - bpc_pkg::LIDX_W'(1);
          state_d = S_SCAN_RD;
        end else begin
          limb_d      = rdata_a;
          out_valid_d = 1'b1;
          lead_d      = 1'b0;
          state_d     = S_SEND;
        end
      end
      S_SEND: begin
        if (count_o.ready) begin
          out_valid_d = 1'b0;
          if (i_q == '0) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q - bpc_pkg::LIDX_W'(1);
            state_d = S_SCAN_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lead_q      <= 1'b0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lead_q      <= lead_d;
      i_q         <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q   <= amt_d;
    kmax_q  <= kmax_d;
    k_q     <= k_d;
    n_q     <= n_d;
    dbase_q <= dbase_d;
    kbase_q <= kbase_d;
    limb_q  <= limb_d;
  end

  // Clear writes and limb write-backs never fall in the same cycle
  assign mem_wr = clr_wr.we ? clr_wr : add_wr;

  bpc_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  bpc_adder u_adder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (add_req),
    .dst_i  (rdata_a),
    .src_i  (rdata_b),
    .wr_o   (add_wr)
  );

  // Drive the ports
  assign query_i.ready      = (state_q == S_IDLE);
  assign count_o.valid      = out_valid_q;
  assign count_o.limb       = limb_q;
  assign count_o.limb_index = bpc_pkg::POS_W'(i_q);
  assign count_o.last       = (i_q == '0);

  a_valid_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_SEND))
    else $error("count word shown outside the send state");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_wr.we && add_wr.we))
    else $error("clear write collides with limb write-back");

  a_last_ends_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_o.valid && count_o.ready && count_o.last) |=> (state_q == S_IDLE))
    else $error("block not idle after the last limb");

  a_limb_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    i_q <= LAST_LIMB)
    else $error("limb index beyond the row");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT    = 20_000_000;
  localparam int unsigned RANDOM_QUERIES = 100;
  localparam int unsigned HOLD_AT_WORD   = 30;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned N_DIRECTED     = 17;

  typedef struct {
    logic [bpc_pkg::LIMB_W-1:0] limb;
    logic [bpc_pkg::POS_W-1:0]  limb_index;
    logic                       last;
  } count_word_t;

  // Partition counts per query, held as base-10000 limbs, and the words still owed
  class partition_scoreboard;
    logic [bpc_pkg::LIMB_W-1:0] counts [0:bpc_pkg::MAX_AMOUNT][0:bpc_pkg::LIMBS-1];
    count_word_t                owed_words[$];
    int unsigned                mismatches;

    // Rebuild the count table for one query and queue its limbs, top limb first
    function void note_query(input logic [bpc_pkg::AMT_W-1:0] amount,
                             input logic [bpc_pkg::AMT_W-1:0] max_part);
      int unsigned top_n;
      int unsigned top_k;
      int unsigned len;
      int unsigned sum;
      int unsigned carry;
      int unsigned pos;
      count_word_t w;
      top_n = amount;
      if (top_n > bpc_pkg::MAX_AMOUNT) top_n = bpc_pkg::MAX_AMOUNT;
      top_k = max_part;
      if (top_k > top_n) top_k = top_n;
      for (int unsigned n = 0; n <= top_n; n++)
        for (int unsigned i = 0; i < bpc_pkg::LIMBS; i++) counts[n][i] = '0;
      counts[0][0] = bpc_pkg::LIMB_W'(1);
      // Fold in each part size, rippling carries up the limbs; drop the top carry
      for (int unsigned k = 1; k <= top_k; k++)
        for (int unsigned n = k; n <= top_n; n++) begin
          carry = 0;
          for (int unsigned i = 0; i < bpc_pkg::LIMBS; i++) begin
            sum = counts[n][i] + counts[n-k][i] + carry;
            carry = (sum >= bpc_pkg::LIMB_BASE) ? 1 : 0;
            if (carry != 0) sum = sum - bpc_pkg::LIMB_BASE;
            counts[n][i] = bpc_pkg::LIMB_W'(sum);
          end
        end
      // Skip leading zero limbs, but always send at least one
      len = 1;
      for (int unsigned i = 0; i < bpc_pkg::LIMBS; i++)
        if (counts[top_n][i] != 0) len = i + 1;
      for (int unsigned r = 0; r < len; r++) begin
        pos = len - 1 - r;
        w.limb       = counts[top_n][pos];
        w.limb_index = bpc_pkg::POS_W'(pos);
        w.last       = (pos == 0);
        owed_words.push_back(w);
      end
    endfunction

    // Compare one received word with the oldest owed word
    function void check_word(input logic [bpc_pkg::LIMB_W-1:0] limb,
                             input logic [bpc_pkg::POS_W-1:0] limb_index,
                             input logic last);
      count_word_t w;
      if (owed_words.size() == 0) begin
        $error("unexpected count word: limb %0d, limb_index %0d, last %0d",
               limb, limb_index, last);
        mismatches++;
      end else begin
        w = owed_words.pop_front();
        if (limb !== w.limb) begin
          $error("limb: expected %0d, got %0d", w.limb, limb);
          mismatches++;
        end
        if (limb_index !== w.limb_index) begin
          $error("limb_index: expected %0d, got %0d", w.limb_index, limb_index);
          mismatches++;
        end
        if (last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned queries_sent;
  int unsigned cycle_count;
  partition_scoreboard sb;

  bpc_query_if query_bus ();
  bpc_count_if count_bus ();

  bounded_partition_counter DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .query_i (query_bus),
    .count_o (count_bus)
  );

  // Extremes of both fields and each special case: zero amount, zero max part,
  // max part above amount, a single limb of zero, multi-limb counts
  int unsigned directed_queries [N_DIRECTED][2] = '{
    '{0, 0}, '{0, 1023}, '{1, 0}, '{1023, 0}, '{1, 1}, '{2, 1023}, '{5, 3},
    '{5, 5}, '{10, 4}, '{24, 24}, '{1023, 1}, '{1023, 2}, '{341, 3}, '{682, 2},
    '{60, 60}, '{100, 100}, '{70, 10}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one query word and hold it until accepted; idle in some stretches only
  task automatic send_query(input logic [bpc_pkg::AMT_W-1:0] amount,
                            input logic [bpc_pkg::AMT_W-1:0] max_part);
    int unsigned gap;
    gap = queries_sent[4] ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      query_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    query_bus.valid    <= 1'b1;
    query_bus.amount   <= amount;
    query_bus.max_part <= max_part;
    @(posedge clk_i);
    while (!query_bus.ready) @(posedge clk_i);
    sb.note_query(amount, max_part);
    queries_sent++;
  endtask

  // Query source: reset, directed queries, random queries, then drain
  initial begin : query_source
    int unsigned amt;
    int unsigned mp;
    int unsigned pick;
    sb = new;
    queries_sent = 0;
    query_bus.valid    <= 1'b0;
    query_bus.amount   <= '0;
    query_bus.max_part <= '0;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      send_query(bpc_pkg::AMT_W'(directed_queries[i][0]),
                 bpc_pkg::AMT_W'(directed_queries[i][1]));

    // Mostly small amounts; a few medium full counts and long runs with tiny parts
    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          amt = $urandom_range(32, 70);
          mp  = $urandom_range(0, 1023);
        end
        1: begin
          amt = $urandom_range(0, 1023);
          mp  = $urandom_range(0, 2);
        end
        default: begin
          amt = $urandom_range(0, 24);
          mp  = $urandom_range(0, 1) ? $urandom_range(0, amt + 2) : $urandom_range(0, 1023);
        end
      endcase
      send_query(bpc_pkg::AMT_W'(amt), bpc_pkg::AMT_W'(mp));
    end
    query_bus.valid <= 1'b0;

    while (sb.owed_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Count sink: random stalls, stretches with none, and one long hold-off
  initial begin : count_sink
    int unsigned gap;
    int unsigned words_taken;
    words_taken = 0;
    count_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = words_taken[5] ? 0 : $urandom_range(0, 10);
      if (words_taken == HOLD_AT_WORD) gap = HOLD_CYCLES;
      if (gap > 0) begin
        count_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      count_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!count_bus.valid) @(posedge clk_i);
      sb.check_word(count_bus.limb, count_bus.limb_index, count_bus.last);
      words_taken++;
    end
  end

  // Abort a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bpc_pkg.sv
hdl/bpc_if.sv
hdl/bpc_mem.sv
hdl/bpc_adder.sv
hdl/bounded_partition_counter.sv
tb/testbench.sv
